@@ rtl/assert_macros.svh @@
// assertion macros used by hwu_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define HWU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define HWU_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

@@ rtl/hwu_pkg.sv @@
package hwu_pkg;

    localparam int LINK_SLOTS = 8;
    localparam int LINK_W     = 3;

    localparam logic [23:0] SAT24    = 24'hFFFFFF;
    localparam logic [47:0] TX_SCALE = 48'd65536000000;
    localparam logic [4:0]  DIV_STEPS = 5'd25;

    // register indexes on the config port
    localparam logic [2:0] REG_BDP       = 3'd0;
    localparam logic [2:0] REG_LINK_RATE = 3'd1;
    localparam logic [2:0] REG_ETA       = 3'd2;
    localparam logic [2:0] REG_STAGE_CAP = 3'd3;
    localparam logic [2:0] REG_ADD_INC   = 3'd4;
    localparam logic [2:0] REG_MIN_WIN   = 3'd5;
    localparam logic [2:0] REG_MAX_WIN   = 3'd6;
    localparam logic [2:0] REG_HOP_DELAY = 3'd7;

    typedef struct packed {
        logic [LINK_W-1:0] link_id;
        logic [47:0]       tx_bytes;
        logic [23:0]       queue_len;
        logic [47:0]       hop_time_ps;
        logic [47:0]       ack_time;
        logic [31:0]       ack_no;
        logic [31:0]       highest_sent;
        logic              first_hop;
        logic              last_hop;
    } hwu_item_t;

    typedef struct packed {
        logic [23:0] bdp_bytes;
        logic [19:0] link_rate;
        logic [15:0] eta_q16;
        logic [7:0]  stage_cap;
        logic [15:0] add_inc;
        logic [23:0] min_window;
        logic [23:0] max_window;
        logic [23:0] hop_delay_ps;
    } hwu_cfg_t;

    typedef struct packed {
        logic        start;
        logic [95:0] num;
        logic [95:0] den;
    } hwu_div_req_t;

    typedef struct packed {
        logic        busy;
        logic [23:0] quot;
    } hwu_div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OPEN, ST_CHECK,
        ST_D1_GO, ST_D1_WAIT, ST_M1_GO, ST_M1_WAIT, ST_M2_GO, ST_M2_WAIT,
        ST_D2_GO, ST_D2_WAIT, ST_HOP_END, ST_LAST,
        ST_EW_PREP, ST_EM1_GO, ST_EM1_WAIT, ST_EM2_GO, ST_EM2_WAIT,
        ST_ED_GO, ST_ED_WAIT,
        ST_WIN, ST_WM_GO, ST_WM_WAIT, ST_WD_GO, ST_WD_WAIT,
        ST_COMMIT, ST_EMIT
    } hwu_state_t;

endpackage

@@ rtl/hwu_front.sv @@
module hwu_front
    import hwu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  hwu_item_t in_item,
    output logic      q_valid,
    output hwu_item_t q_item,
    input  logic      q_pop
);

    hwu_item_t   slot_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        push;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rptr_reg];

    // fill count of the two-entry queue
    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop) begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    // word storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/hwu_div.sv @@
module hwu_div
    import hwu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  hwu_div_req_t req,
    output hwu_div_rsp_t rsp
);

    logic         busy_reg;
    logic [4:0]   cnt_reg;
    logic [95:0]  rem_reg;
    logic [119:0] dsh_reg;
    logic [23:0]  quot_reg;
    logic         sat_reg;
    logic         zero_reg;
    logic         ge;

    assign ge       = ({24'd0, rem_reg} >= dsh_reg);
    assign rsp.busy = busy_reg;
    assign rsp.quot = sat_reg ? SAT24 : quot_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == DIV_STEPS) begin
                if (zero_reg || ge) begin
                    busy_reg <= 1'b0;
                end
            end else if (cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // restoring division: an overflow check, then the quotient bits from the MSB down
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.num;
            dsh_reg  <= {req.den, 24'd0};
            cnt_reg  <= DIV_STEPS;
            zero_reg <= (req.den == 96'd0);
            quot_reg <= 24'd0;
            sat_reg  <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == DIV_STEPS) begin
                if (zero_reg || ge) begin
                    sat_reg <= 1'b1;
                end
            end else begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg[95:0];
                end
                quot_reg <= {quot_reg[22:0], ge};
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

endmodule

@@ rtl/hwu_back.sv @@
`include "assert_macros.svh"

module hwu_back
    import hwu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  hwu_cfg_t    cfg,
    input  logic        q_valid,
    input  hwu_item_t   q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_window,
    output logic [23:0] m_candidate_window,
    output logic [23:0] m_utilization_q16,
    output logic        m_committed
);

    hwu_state_t state_reg, state_next;

    hwu_item_t   cur_reg;
    logic [47:0] prev_tx_reg   [LINK_SLOTS];
    logic [23:0] prev_q_reg    [LINK_SLOTS];
    logic [47:0] prev_time_reg [LINK_SLOTS];
    logic [LINK_SLOTS-1:0] link_valid_reg, seen_reg;

    logic [23:0] util_reg, cwnd_reg, mu_reg;
    logic [7:0]  stage_reg;
    logic [31:0] last_seq_reg;
    logic [47:0] latest_reg, best_int_reg;
    logic        mu_valid_reg, new_reg, mult_reg;
    logic [3:0]  hop_cnt_reg;

    logic [23:0] minq_reg, t1_reg, t2_reg, cand_reg;
    logic [47:0] dtx_reg, dt_reg;
    logic [95:0] p1_reg;
    logic [28:0] big_t_reg, tt_reg;
    logic        comm_reg;

    logic        m_valid_reg, m_comm_reg;
    logic [23:0] m_win_reg, m_cand_reg, m_util_reg;

    // shared multiplier, 16 bits of the second operand a cycle
    logic        mul_start, mul_busy_reg;
    logic [47:0] mul_a, mul_b, ma_reg, mb_reg;
    logic [95:0] acc_reg;
    logic [1:0]  mcnt_reg;
    logic [63:0] pprod;

    hwu_div_req_t div_req;
    hwu_div_rsp_t div_rsp;

    logic [LINK_W-1:0] lid;
    logic        out_free, mult;
    logic [24:0] usum, csum_div, csum_add;
    logic [23:0] usat, clamp_lo, clamp_win;
    logic [28:0] tprod;

    hwu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign lid      = cur_reg.link_id;
    assign out_free = !m_valid_reg || m_ready;
    assign usum     = {1'b0, t1_reg} + {1'b0, t2_reg};
    assign usat     = usum[24] ? SAT24 : usum[23:0];
    assign csum_div = {1'b0, div_rsp.quot} + {9'd0, cfg.add_inc};
    assign csum_add = {1'b0, cwnd_reg} + {9'd0, cfg.add_inc};
    assign mult     = (util_reg >= {8'd0, cfg.eta_q16}) || (stage_reg >= cfg.stage_cap);
    assign tprod    = 29'({cfg.hop_delay_ps, 1'b0}) * 29'(hop_cnt_reg);
    assign clamp_lo = (cwnd_reg < cfg.min_window) ? cfg.min_window : cwnd_reg;
    assign clamp_win = (clamp_lo > cfg.max_window) ? cfg.max_window : clamp_lo;
    assign pprod    = ma_reg * mb_reg[47:32];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (q_valid) state_next = ST_OPEN;
            ST_OPEN:     state_next = ST_CHECK;
            ST_CHECK: begin
                if (new_reg && !seen_reg[lid] && link_valid_reg[lid]) begin
                    state_next = ST_D1_GO;
                end else begin
                    state_next = ST_LAST;
                end
            end
            ST_D1_GO:    state_next = ST_D1_WAIT;
            ST_D1_WAIT:  if (!div_rsp.busy) state_next = ST_M1_GO;
            ST_M1_GO:    state_next = ST_M1_WAIT;
            ST_M1_WAIT:  if (!mul_busy_reg) state_next = ST_M2_GO;
            ST_M2_GO:    state_next = ST_M2_WAIT;
            ST_M2_WAIT:  if (!mul_busy_reg) state_next = ST_D2_GO;
            ST_D2_GO:    state_next = ST_D2_WAIT;
            ST_D2_WAIT:  if (!div_rsp.busy) state_next = ST_HOP_END;
            ST_HOP_END:  state_next = ST_LAST;
            ST_LAST: begin
                if (!cur_reg.last_hop) begin
                    state_next = ST_IDLE;
                end else if (!new_reg) begin
                    state_next = ST_EMIT;
                end else if (mu_valid_reg) begin
                    state_next = ST_EW_PREP;
                end else begin
                    state_next = ST_WIN;
                end
            end
            ST_EW_PREP:  state_next = ST_EM1_GO;
            ST_EM1_GO:   state_next = ST_EM1_WAIT;
            ST_EM1_WAIT: if (!mul_busy_reg) state_next = ST_EM2_GO;
            ST_EM2_GO:   state_next = ST_EM2_WAIT;
            ST_EM2_WAIT: if (!mul_busy_reg) state_next = ST_ED_GO;
            ST_ED_GO:    state_next = ST_ED_WAIT;
            ST_ED_WAIT:  if (!div_rsp.busy) state_next = ST_WIN;
            ST_WIN: begin
                if (mult && (util_reg != 24'd0)) begin
                    state_next = ST_WM_GO;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_WM_GO:    state_next = ST_WM_WAIT;
            ST_WM_WAIT:  if (!mul_busy_reg) state_next = ST_WD_GO;
            ST_WD_GO:    state_next = ST_WD_WAIT;
            ST_WD_WAIT:  if (!div_rsp.busy) state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_EMIT;
            ST_EMIT:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // unit requests and queue pop
    always_comb begin
        q_pop         = 1'b0;
        mul_start     = 1'b0;
        mul_a         = 48'd0;
        mul_b         = 48'd0;
        div_req.start = 1'b0;
        div_req.num   = 96'd0;
        div_req.den   = 96'd0;
        case (state_reg)
            ST_IDLE:   q_pop = q_valid;
            ST_D1_GO: begin
                div_req.start = 1'b1;
                div_req.num   = {56'd0, minq_reg, 16'd0};
                div_req.den   = {72'd0, cfg.bdp_bytes};
            end
            ST_M1_GO: begin
                mul_start = 1'b1;
                mul_a     = dtx_reg;
                mul_b     = TX_SCALE;
            end
            ST_M2_GO: begin
                mul_start = 1'b1;
                mul_a     = dt_reg;
                mul_b     = {28'd0, cfg.link_rate};
            end
            ST_D2_GO: begin
                div_req.start = 1'b1;
                div_req.num   = p1_reg;
                div_req.den   = acc_reg;
            end
            ST_EM1_GO: begin
                mul_start = 1'b1;
                mul_a     = {24'd0, util_reg};
                mul_b     = {19'd0, big_t_reg - tt_reg};
            end
            ST_EM2_GO: begin
                mul_start = 1'b1;
                mul_a     = {24'd0, mu_reg};
                mul_b     = {19'd0, tt_reg};
            end
            ST_ED_GO: begin
                div_req.start = 1'b1;
                div_req.num   = p1_reg;
                div_req.den   = {67'd0, big_t_reg};
            end
            ST_WM_GO: begin
                mul_start = 1'b1;
                mul_a     = {24'd0, cwnd_reg};
                mul_b     = {32'd0, cfg.eta_q16};
            end
            ST_WD_GO: begin
                div_req.start = 1'b1;
                div_req.num   = p1_reg;
                div_req.den   = {72'd0, util_reg};
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
        end else if (mul_start) begin
            mul_busy_reg <= 1'b1;
        end else if (mul_busy_reg && (mcnt_reg == 2'd0)) begin
            mul_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_start) begin
            ma_reg   <= mul_a;
            mb_reg   <= mul_b;
            acc_reg  <= 96'd0;
            mcnt_reg <= 2'd2;
        end else if (mul_busy_reg) begin
            acc_reg  <= {acc_reg[79:0], 16'd0} + {32'd0, pprod};
            mb_reg   <= {mb_reg[31:0], 16'd0};
            mcnt_reg <= mcnt_reg - 2'd1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            link_valid_reg <= '0;
            seen_reg       <= '0;
            util_reg       <= 24'd65536;
            cwnd_reg       <= 24'd60000;
            stage_reg      <= 8'd0;
            last_seq_reg   <= 32'd0;
            latest_reg     <= 48'd0;
            mu_valid_reg   <= 1'b0;
            best_int_reg   <= 48'd0;
            hop_cnt_reg    <= 4'd0;
            new_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_OPEN: begin
                    if (cur_reg.first_hop) begin
                        seen_reg     <= '0;
                        mu_valid_reg <= 1'b0;
                        best_int_reg <= 48'd0;
                        hop_cnt_reg  <= 4'd0;
                        new_reg      <= (cur_reg.ack_time > latest_reg);
                        if (cur_reg.ack_time > latest_reg) begin
                            latest_reg <= cur_reg.ack_time;
                        end
                    end
                end
                ST_CHECK: begin
                    if (new_reg && !seen_reg[lid]) begin
                        seen_reg[lid] <= 1'b1;
                        if (hop_cnt_reg != 4'd15) begin
                            hop_cnt_reg <= hop_cnt_reg + 4'd1;
                        end
                    end
                end
                ST_HOP_END: begin
                    if (!mu_valid_reg || (usat > mu_reg)) begin
                        mu_valid_reg <= 1'b1;
                        best_int_reg <= dt_reg;
                    end
                end
                ST_ED_WAIT: begin
                    if (!div_rsp.busy) begin
                        util_reg <= div_rsp.quot;
                    end
                end
                ST_COMMIT: begin
                    if (cur_reg.ack_no > last_seq_reg) begin
                        cwnd_reg     <= cand_reg;
                        last_seq_reg <= cur_reg.highest_sent + 32'd1;
                        if (mult_reg) begin
                            stage_reg <= 8'd0;
                        end else if (stage_reg != 8'd255) begin
                            stage_reg <= stage_reg + 8'd1;
                        end
                    end
                    link_valid_reg <= seen_reg;
                    new_reg        <= 1'b0;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        cwnd_reg    <= clamp_win;
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    mu_valid_reg <= mu_valid_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_reg <= q_item;
                end
            end
            ST_CHECK: begin
                minq_reg <= (cur_reg.queue_len < prev_q_reg[lid]) ?
                            cur_reg.queue_len : prev_q_reg[lid];
                dtx_reg  <= cur_reg.tx_bytes - prev_tx_reg[lid];
                dt_reg   <= cur_reg.hop_time_ps - prev_time_reg[lid];
                if (new_reg && !seen_reg[lid]) begin
                    prev_tx_reg[lid]   <= cur_reg.tx_bytes;
                    prev_q_reg[lid]    <= cur_reg.queue_len;
                    prev_time_reg[lid] <= cur_reg.hop_time_ps;
                end
            end
            ST_D1_WAIT:  if (!div_rsp.busy) t1_reg <= div_rsp.quot;
            ST_M1_WAIT:  if (!mul_busy_reg) p1_reg <= acc_reg;
            ST_D2_WAIT:  if (!div_rsp.busy) t2_reg <= div_rsp.quot;
            ST_HOP_END: begin
                if (!mu_valid_reg || (usat > mu_reg)) begin
                    mu_reg <= usat;
                end
            end
            ST_LAST: begin
                cand_reg  <= 24'd0;
                comm_reg  <= 1'b0;
                big_t_reg <= (tprod <= 29'd1) ? 29'd1 : tprod;
            end
            ST_EW_PREP: begin
                tt_reg <= (best_int_reg < {19'd0, big_t_reg}) ?
                          best_int_reg[28:0] : big_t_reg;
            end
            ST_EM1_WAIT: if (!mul_busy_reg) p1_reg <= acc_reg;
            ST_EM2_WAIT: if (!mul_busy_reg) p1_reg <= p1_reg + acc_reg;
            ST_WIN: begin
                mult_reg <= mult;
                if (!mult) begin
                    cand_reg <= csum_add[24] ? SAT24 : csum_add[23:0];
                end else if (util_reg == 24'd0) begin
                    cand_reg <= SAT24;
                end
            end
            ST_WM_WAIT:  if (!mul_busy_reg) p1_reg <= acc_reg;
            ST_WD_WAIT: begin
                if (!div_rsp.busy) begin
                    cand_reg <= csum_div[24] ? SAT24 : csum_div[23:0];
                end
            end
            ST_COMMIT: begin
                comm_reg <= (cur_reg.ack_no > last_seq_reg);
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_win_reg  <= clamp_win;
                    m_cand_reg <= cand_reg;
                    m_util_reg <= util_reg;
                    m_comm_reg <= comm_reg;
                end
            end
            default: begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign m_window           = m_win_reg;
    assign m_candidate_window = m_cand_reg;
    assign m_utilization_q16  = m_util_reg;
    assign m_committed        = m_comm_reg;

    `HWU_NEVER(a_div_overlap, div_req.start && div_rsp.busy, "divider restarted while busy")
    `HWU_NEVER(a_mul_overlap, mul_start && mul_busy_reg, "multiplier restarted while busy")
    `HWU_ASSERT(a_win_clamp, (state_reg == ST_EMIT) && out_free |=> m_valid_reg && (m_win_reg <= $past(cfg.max_window)), "window above upper clamp")

endmodule

@@ rtl/hpcc_window_update.sv @@
// HPCC sender window controller.
// Input channel (s_*): one telemetry record per word, ordered by ascending
// link id; s_first_hop opens an acknowledgement and s_last_hop closes it.
// Result channel (m_*): one word per closing record carrying the clamped
// window, the candidate window, the utilization EWMA and the commit flag.
// Config: APB port, eight 32-bit registers at byte offsets 0x00..0x1c.
// A two-word queue in front decouples the input from the sequencer, and
// an output register holds a result while the next records keep flowing.
// Processing: a record for a link with no history skips the arithmetic; a
// record for a known link runs the shared 25-step restoring divider twice
// plus two 3-step multiplies. The closing record of a new acknowledgement
// adds the utilization and window updates.
// Records are worked one at a time through the shared units.
// Reset: all link history invalid, window 60000, utilization 1.0, config
// registers at their defaults; no clearing pass is needed.
// Stall: a stalled receiver blocks the sequencer only when it must hand
// over a new result; the queue then fills and s_ready drops.
module hpcc_window_update
    import hwu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [LINK_W-1:0] s_link_id,
    input  logic [47:0]       s_tx_bytes,
    input  logic [23:0]       s_queue_len,
    input  logic [47:0]       s_hop_time_ps,
    input  logic [47:0]       s_ack_time,
    input  logic [31:0]       s_ack_no,
    input  logic [31:0]       s_highest_sent,
    input  logic              s_first_hop,
    input  logic              s_last_hop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [23:0]       m_window,
    output logic [23:0]       m_candidate_window,
    output logic [23:0]       m_utilization_q16,
    output logic              m_committed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    hwu_cfg_t  cfg_reg;
    hwu_item_t in_item, q_item;
    logic      q_valid, q_pop;
    logic      wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bdp_bytes    <= 24'd60000;
            cfg_reg.link_rate    <= 20'd12500;
            cfg_reg.eta_q16      <= 16'd62259;
            cfg_reg.stage_cap    <= 8'd5;
            cfg_reg.add_inc      <= 16'd750;
            cfg_reg.min_window   <= 24'd3000;
            cfg_reg.max_window   <= SAT24;
            cfg_reg.hop_delay_ps <= 24'd500000;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BDP:       cfg_reg.bdp_bytes    <= pwdata[23:0];
                REG_LINK_RATE: cfg_reg.link_rate    <= pwdata[19:0];
                REG_ETA:       cfg_reg.eta_q16      <= pwdata[15:0];
                REG_STAGE_CAP: cfg_reg.stage_cap    <= pwdata[7:0];
                REG_ADD_INC:   cfg_reg.add_inc      <= pwdata[15:0];
                REG_MIN_WIN:   cfg_reg.min_window   <= pwdata[23:0];
                REG_MAX_WIN:   cfg_reg.max_window   <= pwdata[23:0];
                REG_HOP_DELAY: cfg_reg.hop_delay_ps <= pwdata[23:0];
                default:       cfg_reg.bdp_bytes    <= cfg_reg.bdp_bytes;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (reg_idx)
            REG_BDP:       prdata = {8'd0, cfg_reg.bdp_bytes};
            REG_LINK_RATE: prdata = {12'd0, cfg_reg.link_rate};
            REG_ETA:       prdata = {16'd0, cfg_reg.eta_q16};
            REG_STAGE_CAP: prdata = {24'd0, cfg_reg.stage_cap};
            REG_ADD_INC:   prdata = {16'd0, cfg_reg.add_inc};
            REG_MIN_WIN:   prdata = {8'd0, cfg_reg.min_window};
            REG_MAX_WIN:   prdata = {8'd0, cfg_reg.max_window};
            REG_HOP_DELAY: prdata = {8'd0, cfg_reg.hop_delay_ps};
            default:       prdata = 32'd0;
        endcase
    end

    // input word
    always_comb begin
        in_item.link_id      = s_link_id;
        in_item.tx_bytes     = s_tx_bytes;
        in_item.queue_len    = s_queue_len;
        in_item.hop_time_ps  = s_hop_time_ps;
        in_item.ack_time     = s_ack_time;
        in_item.ack_no       = s_ack_no;
        in_item.highest_sent = s_highest_sent;
        in_item.first_hop    = s_first_hop;
        in_item.last_hop     = s_last_hop;
    end

    hwu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    hwu_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_window           (m_window),
        .m_candidate_window (m_candidate_window),
        .m_utilization_q16  (m_utilization_q16),
        .m_committed        (m_committed)
    );

endmodule
